[hw/rtl/seeded_crc32_report_trailer_defines.svh]
// Assertion helpers for the seeded CRC-32 report trailer.
`ifndef SEEDED_CRC32_REPORT_TRAILER_DEFINES_SVH
`define SEEDED_CRC32_REPORT_TRAILER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SCRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SCRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/scrc_pkg.sv]
package scrc_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] SEED_OUTPUT  = 32'hEADA_2D49;
    localparam logic [31:0] SEED_FEATURE = 32'h2060_EFC3;

    localparam logic MODE_OUTPUT  = 1'b0;
    localparam logic MODE_FEATURE = 1'b1;

    localparam int unsigned TRAILER_BYTES = 4;
    localparam int unsigned TRL_CNT_W     = $clog2(TRAILER_BYTES + 1);

    // one accepted input transaction, as seen by the output stage
    typedef struct packed {
        logic       accept;
        logic [7:0] data;
        logic       last;
    } t_item;

    // reflected CRC-32, one byte folded in LSB first
    function automatic logic [31:0] fold_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/scrc_crc.sv]
module scrc_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_mode,
    input  logic        i_last_byte,
    output logic [31:0] o_fin
);
    import scrc_pkg::*;

    logic [31:0] r_crc;
    logic        r_in_frame;
    logic [31:0] crc_start;
    logic [31:0] crc_next;

    // mode only matters on the first byte of a report
    assign crc_start = r_in_frame ? r_crc
                     : ((i_mode == MODE_FEATURE) ? ~SEED_FEATURE : ~SEED_OUTPUT);
    assign crc_next  = fold_byte(crc_start, i_data_byte);
    assign o_fin     = ~crc_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else if (i_accept) begin
            r_in_frame <= !i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_crc <= crc_next;
        end
    end

endmodule

[hw/rtl/scrc_emit.sv]
module scrc_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scrc_pkg::t_item i_item,
    input  logic [31:0]   i_fin,
    output logic          o_busy,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_is_trailer,
    output logic          o_frame_end
);
    import scrc_pkg::*;

    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_trailer;
    logic                 r_end;
    logic [31:0]          r_fin;
    logic [TRL_CNT_W-1:0] r_trl_cnt;
    logic                 out_free;
    logic                 trl_pending;

    // result register is empty or is being taken this cycle
    assign out_free    = !r_valid || !i_out_stall;
    assign trl_pending = (r_trl_cnt != '0);
    assign o_busy      = !out_free || trl_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_trl_cnt <= '0;
        end else if (i_item.accept) begin
            r_valid <= 1'b1;
            if (i_item.last) begin
                r_trl_cnt <= TRL_CNT_W'(TRAILER_BYTES);
            end
        end else if (out_free) begin
            r_valid <= trl_pending;
            if (trl_pending) begin
                r_trl_cnt <= r_trl_cnt - TRL_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.accept) begin
            r_byte    <= i_item.data;
            r_trailer <= 1'b0;
            r_end     <= 1'b0;
            r_fin     <= i_fin;
        end else if (out_free && trl_pending) begin
            r_byte    <= r_fin[7:0];
            r_trailer <= 1'b1;
            r_end     <= (r_trl_cnt == TRL_CNT_W'(1));
            r_fin     <= r_fin >> 8;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_is_trailer = r_trailer;
    assign o_frame_end  = r_end;

endmodule

[hw/rtl/seeded_crc32_report_trailer.sv]
// Streams report payload bytes one per transaction and echoes each one; the byte
// marked last is followed by four CRC trailer bytes (reflected CRC-32, poly
// 0xEDB88320, start value picked by mode on the first byte, result complemented,
// LSB first), the fourth flagged by o_frame_end. Payload bytes pass a single
// result register and flow at one per cycle while i_out_stall is low; the last
// byte of a report holds off input while the trailer drains through that same
// register. Each payload byte is echoed in the cycle after it is accepted.
module seeded_crc32_report_trailer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_mode,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_trailer,
    output logic       o_frame_end
);
    import scrc_pkg::*;

    t_item       item;
    logic [31:0] fin;
    logic        busy;

    assign o_in_stall  = busy;
    assign item.accept = i_in_valid && !busy;
    assign item.data   = i_data_byte;
    assign item.last   = i_last_byte;

    scrc_crc u_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (item.accept),
        .i_data_byte (i_data_byte),
        .i_mode      (i_mode),
        .i_last_byte (i_last_byte),
        .o_fin       (fin)
    );

    scrc_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_fin        (fin),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_is_trailer (o_is_trailer),
        .o_frame_end  (o_frame_end)
    );

endmodule

[hw/rtl/scrc_checker.sv]
`include "seeded_crc32_report_trailer_defines.svh"

module scrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_data_byte,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_is_trailer,
    input logic       o_frame_end
);

    `SCRC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_is_trailer) && $stable(o_frame_end), "stalled result changed")

    `SCRC_ASSERT(a_end_is_trailer, o_out_valid && o_frame_end |-> o_is_trailer, "frame end on non-trailer byte")

    `SCRC_ASSERT(a_echo_next, i_in_valid && !o_in_stall |=> o_out_valid && !o_is_trailer && (o_out_byte == $past(i_data_byte)), "payload byte not echoed")

    `SCRC_ASSERT(a_trailer_follows, i_in_valid && !o_in_stall && i_last_byte |=> o_in_stall, "input taken before trailer")

    `SCRC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind seeded_crc32_report_trailer scrc_checker u_scrc_checker (.*);
